@@ rtl/cba_pkg.sv @@
`timescale 1ns / 1ps
package cba_pkg;

  // Fixed field widths of the transaction payloads.
  localparam int OP_W     = 2;
  localparam int HEAD_W   = 12;
  localparam int LEN_W    = 19;
  localparam int BYTES_W  = 13;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 13;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_STORE = 2'd0;
  localparam logic [OP_W-1:0] OP_ERASE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_POS   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SMALL_BUF = 3'd5;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd6;

  // Configuration register indices.
  localparam logic CFG_PAYLOAD = 1'b0;
  localparam logic CFG_RING    = 1'b1;

  // Largest legal payload size per block.
  localparam int PAY_MAX = 4096;

  typedef struct packed {
    logic [LEN_W-1:0] a;
    logic [LEN_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [LEN_W-1:0] diff;
    logic             lt;
    logic             le;
  } alu_res_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_FL_RD,
    S_FL_WR,
    S_SCAN_RD,
    S_SCAN_WR,
    S_WR_RD,
    S_WR_WR,
    S_WR_FIN,
    S_RD_RD,
    S_RD_WR,
    S_PARK,
    S_REL_RD,
    S_REL_WR,
    S_FLUSH,
    S_RESP,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

endpackage

@@ rtl/cba_alu.sv @@
`timescale 1ns / 1ps
// Shared subtract and compare unit.
module cba_alu (
  input  cba_pkg::alu_req_t req,
  output cba_pkg::alu_res_t res
);

  assign res.diff = req.a - req.b;
  assign res.lt   = (req.a < req.b);
  assign res.le   = (req.a <= req.b);

endmodule

@@ rtl/cba_block_mem.sv @@
`timescale 1ns / 1ps
// Link and used-length store of the block pool, one write and one read a cycle.
module cba_block_mem #(
  parameter int DEPTH = 4096,
  parameter int PW    = 12
) (
  input  logic                          clk,
  input  logic [PW-1:0]                 raddr,
  output logic [PW-1:0]                 rd_link,
  output logic [cba_pkg::BYTES_W-1:0]   rd_len,
  input  logic [PW-1:0]                 waddr,
  input  logic                          we_link,
  input  logic                          we_len,
  input  logic [PW-1:0]                 wlink,
  input  logic [cba_pkg::BYTES_W-1:0]   wlen
);

  logic [PW-1:0]               link_mem [DEPTH];
  logic [cba_pkg::BYTES_W-1:0] len_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (we_link) begin
      link_mem[waddr] <= wlink;
    end
    if (we_len) begin
      len_mem[waddr] <= wlen;
    end
    rd_link <= link_mem[raddr];
    rd_len  <= len_mem[raddr];
  end

endmodule

@@ rtl/cba_result_buf.sv @@
`timescale 1ns / 1ps
// Holds the per-block results of a chain until they are sent out.
module cba_result_buf #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int W     = 25
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/chained_block_allocator_top.sv @@
// Erase and ring flush release their blocks one by one; a store divides the length, takes
// blocks from the free list or a scan of the pool, writes the chain and then emits its
// results; a read walks the chain and then emits its results. All steps share one memory.
// Throughput: one transaction at a time; the input is not ready until the last result
// has been loaded into the output register.
// Reset (synchronous, rst_n low): a clearing pass over every block zeroes the pool.
`timescale 1ns / 1ps
module chained_block_allocator_top #(
  parameter int NUM_BLOCKS = 4096,
  parameter int MAX_CHAIN  = 64,
  parameter int RING_MAX   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input transactions.
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata, from bit 0: chain_head[11:0], data_len[30:12], read_capacity[49:31], zeros.
  input  logic [55:0] in_tdata,
  // in_tuser: op[1:0].
  input  logic [1:0]  in_tuser,
  // Result transactions.
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata, from bit 0: new_head[11:0], block_pos[23:12], block_bytes[36:24],
  // total_bytes[55:37], free_blocks[67:56], zeros.
  output logic [71:0] out_tdata,
  // out_tuser: status[2:0].
  output logic [2:0]  out_tuser,
  output logic        out_tlast,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  // Position width, wide head width, chain counter, result buffer and ring widths.
  localparam int PW  = $clog2(NUM_BLOCKS);
  localparam int HW  = (PW > 12) ? PW : 12;
  localparam int CW  = $clog2(MAX_CHAIN + 2);
  localparam int BW  = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;
  localparam int RSW = $clog2(RING_MAX + 1);
  localparam int RIW = (RING_MAX > 1) ? $clog2(RING_MAX) : 1;
  localparam int unsigned LIMIT = NUM_BLOCKS - 1;
  localparam logic [PW-1:0] POOL_LIM = PW'(LIMIT);
  localparam int RW = PW + cba_pkg::BYTES_W;

  // Input fields.
  logic [1:0]                 in_op;
  logic [11:0]                in_head;
  logic [cba_pkg::LEN_W-1:0]  in_len;
  logic [cba_pkg::LEN_W-1:0]  in_cap;

  assign in_op   = in_tuser;
  assign in_head = in_tdata[11:0];
  assign in_len  = in_tdata[30:12];
  assign in_cap  = in_tdata[49:31];

  // Control state.
  cba_pkg::state_t state_r, state_nxt;
  cba_pkg::state_t ret_r, ret_nxt;
  logic [PW-1:0]   free_head_r, free_head_nxt;
  logic [PW-1:0]   scan_r, scan_nxt;
  logic [PW-1:0]   fc_r, fc_nxt;
  logic [HW-1:0]   ring_r [RING_MAX];
  logic [RIW-1:0]  ridx_r, ridx_nxt;
  logic [RSW-1:0]  rsize_r, rsize_nxt;
  logic [RSW-1:0]  pend_r, pend_nxt;
  logic [RSW-1:0]  fi_r, fi_nxt;
  logic            flush_cfg_r, flush_cfg_nxt;
  logic [cba_pkg::BYTES_W-1:0] pay_r, pay_nxt;
  logic [PW-1:0]   clr_r, clr_nxt;
  logic            out_valid_r;

  // Working registers of the sequencer.
  logic [1:0]                   op_r, op_nxt;
  logic [HW-1:0]                head_r, head_nxt;
  logic [cba_pkg::LEN_W-1:0]    len_r, len_nxt;
  logic [cba_pkg::LEN_W-1:0]    rem_r, rem_nxt;
  logic [cba_pkg::LEN_W-1:0]    capl_r, capl_nxt;
  logic [CW-1:0]                need_r, need_nxt;
  logic [CW-1:0]                got_r, got_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [CW-1:0]                reln_r, reln_nxt;
  logic [PW-1:0]                cur_r, cur_nxt;
  logic [HW-1:0]                nxt_r, nxt_nxt;
  logic [PW-1:0]                chain_r, chain_nxt;
  logic [PW-1:0]                start_r, start_nxt;
  logic [PW-1:0]                j_r, j_nxt;
  logic [BW-1:0]                k_r, k_nxt;
  logic [cba_pkg::LEN_W-1:0]    run_r, run_nxt;
  logic [cba_pkg::STATUS_W-1:0] status_r, status_nxt;

  // Output register payload.
  logic [cba_pkg::STATUS_W-1:0] o_status_r;
  logic [11:0]                  o_head_r, o_pos_r, o_free_r;
  logic [cba_pkg::BYTES_W-1:0]  o_bytes_r;
  logic [cba_pkg::LEN_W-1:0]    o_total_r;
  logic                         o_last_r;

  // Memory, buffer and unit connections.
  logic [PW-1:0]               mem_raddr, mem_waddr, mem_wlink, rd_link;
  logic                        mem_we_link, mem_we_len;
  logic [cba_pkg::BYTES_W-1:0] mem_wlen, rd_len;
  logic                        buf_we;
  logic [RW-1:0]               buf_wdata, buf_rdata;
  cba_pkg::alu_req_t           alu_req;
  cba_pkg::alu_res_t           alu_res;

  // Ring access.
  logic            ring_we;
  logic [RIW-1:0]  ring_widx, ring_ridx, park_idx;
  logic [HW-1:0]   ring_wdata, ring_rdata;
  logic [RSW-1:0]  park_inc;
  logic [RIW-1:0]  park_next;

  // Shared decisions.
  logic in_acc, cfg_acc, out_free, out_load;
  logic ring_ok, pay_ok, nxt_bad;
  logic fl_go, sc_go, wr_go, wr_ok, rel_go, emit_last;
  logic [cba_pkg::BYTES_W-1:0] rd_b;
  logic [cba_pkg::BYTES_W-1:0] buf_bytes;
  logic [PW-1:0]               buf_pos;

  cba_block_mem #(.DEPTH(NUM_BLOCKS), .PW(PW)) u_mem (
    .clk     (clk),
    .raddr   (mem_raddr),
    .rd_link (rd_link),
    .rd_len  (rd_len),
    .waddr   (mem_waddr),
    .we_link (mem_we_link),
    .we_len  (mem_we_len),
    .wlink   (mem_wlink),
    .wlen    (mem_wlen)
  );

  cba_result_buf #(.DEPTH(MAX_CHAIN), .AW(BW), .W(RW)) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (cnt_r[BW-1:0]),
    .wdata (buf_wdata),
    .raddr (k_r),
    .rdata (buf_rdata)
  );

  cba_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // Configuration is taken while idle and during the clearing pass; it wins over input.
  assign cfg_ready = (state_r == cba_pkg::S_IDLE) || (state_r == cba_pkg::S_CLEAR);
  assign in_tready = (state_r == cba_pkg::S_IDLE) && !cfg_valid;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign ring_ok   = (cfg_data != '0) && (32'(cfg_data) <= RING_MAX);
  assign pay_ok    = (cfg_data != '0) && (32'(cfg_data) <= cba_pkg::PAY_MAX);

  // The output register may be refilled in the cycle its transaction completes.
  assign out_free = !out_valid_r || out_tready;

  assign nxt_bad = (32'(nxt_r) >= LIMIT);
  assign fl_go   = (got_r < need_r) && (cur_r != '0) && (cur_r < POOL_LIM);
  assign sc_go   = (got_r < need_r) && (j_r < POOL_LIM);
  assign wr_go   = (nxt_r != '0) && (rem_r != '0) && (cnt_r < CW'(MAX_CHAIN)) && !nxt_bad;
  assign wr_ok   = (rem_r == '0) && (cnt_r != '0);
  assign rel_go  = (nxt_r != '0) && (32'(reln_r) <= MAX_CHAIN) && !nxt_bad;

  // The ring is read at the flush index or at the slot the next park takes.
  assign park_idx   = (32'(ridx_r) >= 32'(rsize_r)) ? '0 : ridx_r;
  assign park_inc   = RSW'(park_idx) + RSW'(1);
  assign park_next  = (park_inc == rsize_r) ? '0 : park_inc[RIW-1:0];
  assign ring_ridx  = (state_r == cba_pkg::S_FLUSH) ? fi_r[RIW-1:0] : park_idx;
  assign ring_rdata = ring_r[ring_ridx];

  // An inner block reports the full payload, the final one its capped used length.
  assign rd_b = (rd_link != '0) ? pay_r : ((rd_len > pay_r) ? pay_r : rd_len);

  assign buf_pos   = buf_rdata[RW-1:cba_pkg::BYTES_W];
  assign buf_bytes = buf_rdata[cba_pkg::BYTES_W-1:0];
  assign emit_last = ((CW'(k_r) + CW'(1)) == cnt_r);

  // Shared unit operand selection.
  always_comb begin
    alu_req.a = rem_r;
    alu_req.b = cba_pkg::LEN_W'(pay_r);
    unique case (state_r)
      cba_pkg::S_IDLE:  alu_req.a = in_cap;
      cba_pkg::S_RD_RD: alu_req.a = capl_r;
      cba_pkg::S_RD_WR: begin
        alu_req.a = capl_r;
        alu_req.b = cba_pkg::LEN_W'(rd_b);
      end
      default: alu_req.a = rem_r;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cba_pkg::S_CLEAR: begin
        if (clr_r == POOL_LIM) state_nxt = cba_pkg::S_IDLE;
      end
      cba_pkg::S_IDLE: begin
        if (cfg_acc && (cfg_index == cba_pkg::CFG_RING) && ring_ok) begin
          state_nxt = cba_pkg::S_FLUSH;
        end else if (in_acc) begin
          unique case (in_op)
            cba_pkg::OP_STORE: begin
              if (in_len != '0)       state_nxt = cba_pkg::S_DIV;
              else if (in_head != '0) state_nxt = cba_pkg::S_PARK;
              else                    state_nxt = cba_pkg::S_RESP;
            end
            cba_pkg::OP_ERASE: state_nxt = cba_pkg::S_PARK;
            cba_pkg::OP_READ:  state_nxt = alu_res.lt ? cba_pkg::S_RESP : cba_pkg::S_RD_RD;
            cba_pkg::OP_FLUSH: state_nxt = cba_pkg::S_FLUSH;
            default:           state_nxt = cba_pkg::S_IDLE;
          endcase
        end
      end
      cba_pkg::S_DIV: begin
        if (rem_r == '0) begin
          state_nxt = (32'(need_r) > 32'(fc_r)) ? cba_pkg::S_RESP : cba_pkg::S_FL_RD;
        end else if (need_r == CW'(MAX_CHAIN)) begin
          state_nxt = cba_pkg::S_RESP;
        end
      end
      cba_pkg::S_FL_RD: begin
        if (fl_go)                 state_nxt = cba_pkg::S_FL_WR;
        else if (got_r == need_r)  state_nxt = cba_pkg::S_WR_RD;
        else                       state_nxt = cba_pkg::S_SCAN_RD;
      end
      cba_pkg::S_FL_WR: begin
        state_nxt = (rd_len == '0) ? cba_pkg::S_FL_RD : cba_pkg::S_SCAN_RD;
      end
      cba_pkg::S_SCAN_RD: begin
        if (sc_go)                state_nxt = cba_pkg::S_SCAN_WR;
        else if (got_r < need_r)  state_nxt = cba_pkg::S_RESP;
        else                      state_nxt = cba_pkg::S_WR_RD;
      end
      cba_pkg::S_SCAN_WR: state_nxt = cba_pkg::S_SCAN_RD;
      cba_pkg::S_WR_RD: begin
        if (wr_go)      state_nxt = cba_pkg::S_WR_WR;
        else if (wr_ok) state_nxt = cba_pkg::S_WR_FIN;
        else            state_nxt = cba_pkg::S_RESP;
      end
      cba_pkg::S_WR_WR:  state_nxt = cba_pkg::S_WR_RD;
      cba_pkg::S_WR_FIN: state_nxt = (head_r != '0) ? cba_pkg::S_PARK : cba_pkg::S_EMIT_RD;
      cba_pkg::S_RD_RD: begin
        if (nxt_r == '0) begin
          state_nxt = (cnt_r == '0) ? cba_pkg::S_RESP : cba_pkg::S_EMIT_RD;
        end else if ((32'(cnt_r) >= MAX_CHAIN) || nxt_bad || alu_res.lt) begin
          state_nxt = cba_pkg::S_RESP;
        end else begin
          state_nxt = cba_pkg::S_RD_WR;
        end
      end
      cba_pkg::S_RD_WR:  state_nxt = cba_pkg::S_RD_RD;
      cba_pkg::S_PARK:   state_nxt = (ring_rdata != '0) ? cba_pkg::S_REL_RD : ret_r;
      cba_pkg::S_REL_RD: state_nxt = rel_go ? cba_pkg::S_REL_WR : ret_r;
      cba_pkg::S_REL_WR: state_nxt = cba_pkg::S_REL_RD;
      cba_pkg::S_FLUSH: begin
        if (fi_r == rsize_r) begin
          state_nxt = flush_cfg_r ? cba_pkg::S_IDLE : cba_pkg::S_RESP;
        end else if (ring_rdata != '0) begin
          state_nxt = cba_pkg::S_REL_RD;
        end
      end
      cba_pkg::S_RESP:    if (out_free) state_nxt = cba_pkg::S_IDLE;
      cba_pkg::S_EMIT_RD: state_nxt = cba_pkg::S_EMIT_LD;
      cba_pkg::S_EMIT_LD: begin
        if (out_free) state_nxt = emit_last ? cba_pkg::S_IDLE : cba_pkg::S_EMIT_RD;
      end
      default: state_nxt = cba_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    ret_nxt       = ret_r;
    free_head_nxt = free_head_r;
    scan_nxt      = scan_r;
    fc_nxt        = fc_r;
    ridx_nxt      = ridx_r;
    rsize_nxt     = rsize_r;
    pend_nxt      = pend_r;
    fi_nxt        = fi_r;
    flush_cfg_nxt = flush_cfg_r;
    pay_nxt       = pay_r;
    clr_nxt       = clr_r;
    op_nxt        = op_r;
    head_nxt      = head_r;
    len_nxt       = len_r;
    rem_nxt       = rem_r;
    capl_nxt      = capl_r;
    need_nxt      = need_r;
    got_nxt       = got_r;
    cnt_nxt       = cnt_r;
    reln_nxt      = reln_r;
    cur_nxt       = cur_r;
    nxt_nxt       = nxt_r;
    chain_nxt     = chain_r;
    start_nxt     = start_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    run_nxt       = run_r;
    status_nxt    = status_r;
    mem_raddr     = cur_r;
    mem_waddr     = cur_r;
    mem_we_link   = 1'b0;
    mem_we_len    = 1'b0;
    mem_wlink     = '0;
    mem_wlen      = '0;
    buf_we        = 1'b0;
    buf_wdata     = '0;
    ring_we       = 1'b0;
    ring_widx     = park_idx;
    ring_wdata    = head_r;
    out_load      = 1'b0;

    if (cfg_acc && (cfg_index == cba_pkg::CFG_PAYLOAD) && pay_ok) begin
      pay_nxt = cfg_data;
    end

    unique case (state_r)
      cba_pkg::S_CLEAR: begin
        mem_waddr   = clr_r;
        mem_we_link = 1'b1;
        mem_we_len  = 1'b1;
        clr_nxt     = clr_r + PW'(1);
        // The ring is still all zero here, so a size write needs no flush.
        if (cfg_acc && (cfg_index == cba_pkg::CFG_RING) && ring_ok) begin
          rsize_nxt = cfg_data[RSW-1:0];
          ridx_nxt  = '0;
        end
      end
      cba_pkg::S_IDLE: begin
        if (cfg_acc && (cfg_index == cba_pkg::CFG_RING) && ring_ok) begin
          pend_nxt      = cfg_data[RSW-1:0];
          flush_cfg_nxt = 1'b1;
          fi_nxt        = '0;
        end else if (in_acc) begin
          op_nxt     = in_op;
          head_nxt   = HW'(in_head);
          len_nxt    = in_len;
          rem_nxt    = in_len;
          capl_nxt   = in_cap;
          nxt_nxt    = HW'(in_head);
          need_nxt   = '0;
          cnt_nxt    = '0;
          k_nxt      = '0;
          run_nxt    = '0;
          start_nxt  = '0;
          ret_nxt    = cba_pkg::S_RESP;
          status_nxt = cba_pkg::ST_OK;
          if (in_op == cba_pkg::OP_FLUSH) begin
            flush_cfg_nxt = 1'b0;
            fi_nxt        = '0;
          end else if ((in_op == cba_pkg::OP_READ) && alu_res.lt) begin
            status_nxt = cba_pkg::ST_SMALL_BUF;
          end
        end
      end
      cba_pkg::S_DIV: begin
        // Block count by repeated subtraction of the payload size.
        if (rem_r == '0) begin
          got_nxt = '0;
          cur_nxt = free_head_r;
          if (32'(need_r) > 32'(fc_r)) status_nxt = cba_pkg::ST_NO_SPACE;
        end else if (need_r == CW'(MAX_CHAIN)) begin
          status_nxt = cba_pkg::ST_TOO_LARGE;
        end else begin
          rem_nxt  = alu_res.le ? '0 : alu_res.diff;
          need_nxt = need_r + CW'(1);
        end
      end
      cba_pkg::S_FL_RD: begin
        mem_raddr = cur_r;
        if (!fl_go) begin
          if (got_r == need_r) begin
            start_nxt     = free_head_r;
            free_head_nxt = cur_r;
            nxt_nxt       = HW'(free_head_r);
            rem_nxt       = len_r;
            cnt_nxt       = '0;
          end else begin
            got_nxt   = '0;
            cur_nxt   = scan_r;
            chain_nxt = '0;
            j_nxt     = '0;
          end
        end
      end
      cba_pkg::S_FL_WR: begin
        if (rd_len == '0) begin
          got_nxt = got_r + CW'(1);
          cur_nxt = rd_link;
          if ((got_r + CW'(1)) == need_r) begin
            mem_we_link = 1'b1;
            mem_wlink   = '0;
          end
        end else begin
          got_nxt   = '0;
          cur_nxt   = scan_r;
          chain_nxt = '0;
          j_nxt     = '0;
        end
      end
      cba_pkg::S_SCAN_RD: begin
        mem_raddr = cur_r;
        if (!sc_go) begin
          if (got_r < need_r) begin
            status_nxt = cba_pkg::ST_NO_SPACE;
          end else begin
            start_nxt = chain_r;
            scan_nxt  = cur_r;
            nxt_nxt   = HW'(chain_r);
            rem_nxt   = len_r;
            cnt_nxt   = '0;
          end
        end
      end
      cba_pkg::S_SCAN_WR: begin
        // A free block joins the front of the chain under construction.
        if (rd_len == '0) begin
          mem_we_link = 1'b1;
          mem_wlink   = chain_r;
          chain_nxt   = cur_r;
          got_nxt     = got_r + CW'(1);
        end
        cur_nxt = ((cur_r + PW'(1)) == POOL_LIM) ? PW'(1) : cur_r + PW'(1);
        j_nxt   = j_r + PW'(1);
      end
      cba_pkg::S_WR_RD: begin
        mem_raddr = nxt_r[PW-1:0];
        if (wr_go) begin
          cur_nxt = nxt_r[PW-1:0];
        end else if (!wr_ok) begin
          status_nxt = cba_pkg::ST_BAD_POS;
        end
      end
      cba_pkg::S_WR_WR: begin
        mem_we_len = 1'b1;
        mem_wlen   = alu_res.le ? rem_r[cba_pkg::BYTES_W-1:0] : pay_r;
        buf_we     = 1'b1;
        buf_wdata  = {cur_r, mem_wlen};
        cnt_nxt    = cnt_r + CW'(1);
        nxt_nxt    = HW'(rd_link);
        rem_nxt    = alu_res.le ? '0 : alu_res.diff;
        if (fc_r != '0) fc_nxt = fc_r - PW'(1);
      end
      cba_pkg::S_WR_FIN: begin
        mem_we_link = 1'b1;
        mem_wlink   = '0;
        ret_nxt     = cba_pkg::S_EMIT_RD;
      end
      cba_pkg::S_RD_RD: begin
        mem_raddr = nxt_r[PW-1:0];
        if (nxt_r != '0) begin
          if (32'(cnt_r) >= MAX_CHAIN) status_nxt = cba_pkg::ST_TOO_LONG;
          else if (nxt_bad)            status_nxt = cba_pkg::ST_BAD_POS;
          else if (alu_res.lt)         status_nxt = cba_pkg::ST_OVERFLOW;
          else                         cur_nxt    = nxt_r[PW-1:0];
        end
      end
      cba_pkg::S_RD_WR: begin
        buf_we    = 1'b1;
        buf_wdata = {cur_r, rd_b};
        cnt_nxt   = cnt_r + CW'(1);
        nxt_nxt   = HW'(rd_link);
        capl_nxt  = alu_res.diff;
      end
      cba_pkg::S_PARK: begin
        ring_we    = 1'b1;
        ring_widx  = park_idx;
        ring_wdata = head_r;
        ridx_nxt   = park_next;
        nxt_nxt    = ring_rdata;
        reln_nxt   = '0;
      end
      cba_pkg::S_REL_RD: begin
        mem_raddr = nxt_r[PW-1:0];
        if (rel_go) cur_nxt = nxt_r[PW-1:0];
      end
      cba_pkg::S_REL_WR: begin
        // The released block goes to the front of the free list.
        mem_we_link   = 1'b1;
        mem_we_len    = 1'b1;
        mem_wlink     = free_head_r;
        mem_wlen      = '0;
        free_head_nxt = cur_r;
        if (fc_r < POOL_LIM) fc_nxt = fc_r + PW'(1);
        reln_nxt = reln_r + CW'(1);
        nxt_nxt  = HW'(rd_link);
      end
      cba_pkg::S_FLUSH: begin
        if (fi_r == rsize_r) begin
          ridx_nxt   = '0;
          status_nxt = cba_pkg::ST_OK;
          if (flush_cfg_r) rsize_nxt = pend_r;
        end else begin
          ring_we    = 1'b1;
          ring_widx  = fi_r[RIW-1:0];
          ring_wdata = '0;
          fi_nxt     = fi_r + RSW'(1);
          nxt_nxt    = ring_rdata;
          reln_nxt   = '0;
          ret_nxt    = cba_pkg::S_FLUSH;
        end
      end
      cba_pkg::S_RESP: begin
        out_load = out_free;
      end
      cba_pkg::S_EMIT_RD: begin
        out_load = 1'b0;
      end
      cba_pkg::S_EMIT_LD: begin
        out_load = out_free;
        if (out_free) begin
          k_nxt   = k_r + BW'(1);
          run_nxt = run_r + cba_pkg::LEN_W'(buf_bytes);
        end
      end
      default: out_load = 1'b0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cba_pkg::S_CLEAR;
      ret_r       <= cba_pkg::S_RESP;
      free_head_r <= '0;
      scan_r      <= PW'(1);
      fc_r        <= POOL_LIM;
      ridx_r      <= '0;
      rsize_r     <= (RING_MAX >= 8) ? RSW'(8) : RSW'(RING_MAX);
      pend_r      <= '0;
      fi_r        <= '0;
      flush_cfg_r <= 1'b0;
      pay_r       <= cba_pkg::BYTES_W'(64);
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < RING_MAX; i++) begin
        ring_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      free_head_r <= free_head_nxt;
      scan_r      <= scan_nxt;
      fc_r        <= fc_nxt;
      ridx_r      <= ridx_nxt;
      rsize_r     <= rsize_nxt;
      pend_r      <= pend_nxt;
      fi_r        <= fi_nxt;
      flush_cfg_r <= flush_cfg_nxt;
      pay_r       <= pay_nxt;
      clr_r       <= clr_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (ring_we) begin
        ring_r[ring_widx] <= ring_wdata;
      end
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    head_r   <= head_nxt;
    len_r    <= len_nxt;
    rem_r    <= rem_nxt;
    capl_r   <= capl_nxt;
    need_r   <= need_nxt;
    got_r    <= got_nxt;
    cnt_r    <= cnt_nxt;
    reln_r   <= reln_nxt;
    cur_r    <= cur_nxt;
    nxt_r    <= nxt_nxt;
    chain_r  <= chain_nxt;
    start_r  <= start_nxt;
    j_r      <= j_nxt;
    k_r      <= k_nxt;
    run_r    <= run_nxt;
    status_r <= status_nxt;
    if (out_load) begin
      o_free_r <= 12'(fc_r);
      if (state_r == cba_pkg::S_EMIT_LD) begin
        o_status_r <= cba_pkg::ST_OK;
        o_head_r   <= (op_r == cba_pkg::OP_STORE) ? 12'(start_r) : '0;
        o_pos_r    <= 12'(buf_pos);
        o_bytes_r  <= buf_bytes;
        o_total_r  <= run_r + cba_pkg::LEN_W'(buf_bytes);
        o_last_r   <= emit_last;
      end else begin
        o_status_r <= status_r;
        o_head_r   <= '0;
        o_pos_r    <= '0;
        o_bytes_r  <= '0;
        o_total_r  <= '0;
        o_last_r   <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_status_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {4'b0, o_free_r, o_total_r, o_bytes_r, o_pos_r, o_head_r};

  // No input transaction is taken during the clearing pass after reset.
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cba_pkg::S_CLEAR) |-> !in_tready)
    else $error("input taken during clearing pass");

  // The free count never passes the pool limit.
  a_free_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fc_r) <= LIMIT)
    else $error("free count above pool limit");

  // The ring index stays inside the active ring.
  a_ring_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ridx_r) < 32'(rsize_r))
    else $error("ring index outside active ring");

  // The result buffer is only written inside its depth.
  a_buffer_bound: assert property (@(posedge clk) disable iff (!rst_n)
    buf_we |-> (32'(cnt_r) < MAX_CHAIN))
    else $error("result buffer overrun");

endmodule

@@ tb/chain_alloc_checker.sv @@
`timescale 1ns / 1ps
// Watches the three channels of the allocator, keeps its own copy of the pool
// and predicts every result transaction, then compares them in order.
module chain_alloc_checker
  import cba_pkg::*;
#(
  parameter int NUM_BLOCKS = 4096,
  parameter int MAX_CHAIN  = 64,
  parameter int RING_MAX   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  input  logic [2:0]  out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [12:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam int unsigned POOL_LIMIT = NUM_BLOCKS - 1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HEAD_W-1:0]   new_head;
    logic [HEAD_W-1:0]   block_pos;
    logic [BYTES_W-1:0]  block_bytes;
    logic [LEN_W-1:0]    total_bytes;
    logic [HEAD_W-1:0]   free_blocks;
    logic                last;
  } alloc_result_t;

  alloc_result_t expected_q[$];

  int unsigned link_mem[NUM_BLOCKS];
  int unsigned fill_mem[NUM_BLOCKS];
  int unsigned ring_mem[RING_MAX];
  int unsigned free_head, scan_pos, free_cnt, ring_idx, payload, ring_size;

  initial begin
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      link_mem[i] = 0;
      fill_mem[i] = 0;
    end
    for (int i = 0; i < RING_MAX; i++) ring_mem[i] = 0;
    free_head  = 0;
    scan_pos   = 1;
    free_cnt   = POOL_LIMIT;
    ring_idx   = 0;
    payload    = 64;
    ring_size  = (RING_MAX < 8) ? RING_MAX : 8;
    fail_count = 0;
  end

  assign pending = expected_q.size();

  task automatic push_result(input logic [2:0] st, input int unsigned hd,
                             input int unsigned pos, input int unsigned bytes,
                             input int unsigned total, input bit fin);
    alloc_result_t r;
    r.status      = st;
    r.new_head    = hd[11:0];
    r.block_pos   = pos[11:0];
    r.block_bytes = bytes[12:0];
    r.total_bytes = total[18:0];
    r.free_blocks = free_cnt[11:0];
    r.last        = fin;
    expected_q.push_back(r);
  endtask

  task automatic release_chain(input int unsigned start);
    int unsigned nxt, cur, n;
    nxt = start;
    n   = 0;
    if (start == 0 || start >= POOL_LIMIT) return;
    while (nxt != 0 && n <= MAX_CHAIN) begin
      cur = nxt;
      if (cur >= POOL_LIMIT) return;
      nxt           = link_mem[cur];
      fill_mem[cur] = 0;
      link_mem[cur] = free_head;
      free_head     = cur;
      if (free_cnt < POOL_LIMIT) free_cnt++;
      n++;
    end
  endtask

  task automatic park_chain(input int unsigned pos);
    int unsigned idx, old;
    idx = ring_idx;
    if (idx >= ring_size) idx = 0;
    old           = ring_mem[idx];
    ring_mem[idx] = pos;
    ring_idx      = (idx + 1) % ring_size;
    if (old != 0) release_chain(old);
  endtask

  task automatic flush_ring();
    for (int unsigned i = 0; i < ring_size && i < RING_MAX; i++) begin
      if (ring_mem[i] != 0) begin
        release_chain(ring_mem[i]);
        ring_mem[i] = 0;
      end
    end
    ring_idx = 0;
  endtask

  // The free list is tried first; failing that, a wrap-around scan collects
  // blocks whose fill is zero, relinking them as it goes.
  task automatic take_blocks(input int unsigned need, output bit ok,
                             output int unsigned head);
    int unsigned got, cur, chain, nx;
    ok    = 0;
    head  = 0;
    got   = 0;
    cur   = free_head;
    chain = 0;
    if (need > MAX_CHAIN || need > free_cnt) return;
    while (got < need && cur > 0 && cur < POOL_LIMIT && fill_mem[cur] == 0) begin
      nx = link_mem[cur];
      got++;
      if (got == need) link_mem[cur] = 0;
      cur = nx;
    end
    if (got == need) begin
      head      = free_head;
      free_head = cur;
      ok        = 1;
      return;
    end
    got = 0;
    cur = scan_pos;
    for (int unsigned j = 0; got < need && j < POOL_LIMIT; j++) begin
      if (cur < NUM_BLOCKS && fill_mem[cur] == 0) begin
        link_mem[cur] = chain;
        chain         = cur;
        got++;
      end
      cur++;
      if (cur >= POOL_LIMIT) cur = 1;
    end
    if (got < need) return;
    head     = chain;
    scan_pos = cur;
    ok       = 1;
  endtask

  task automatic predict_item(input logic [1:0] op, input int unsigned head,
                              input int unsigned len, input int unsigned cap);
    int unsigned pos[MAX_CHAIN];
    int unsigned byt[MAX_CHAIN];
    int unsigned n, total, cur, nxt, start, need, left, run, take, b;
    bit ok;
    n     = 0;
    total = 0;
    cur   = 0;
    start = 0;
    if (op == OP_ERASE || op == OP_FLUSH) begin
      if (op == OP_ERASE) park_chain(head);
      else flush_ring();
      push_result(ST_OK, 0, 0, 0, 0, 1);
      return;
    end
    if (op == OP_STORE) begin
      if (len == 0) begin
        if (head != 0) park_chain(head);
        push_result(ST_OK, 0, 0, 0, 0, 1);
        return;
      end
      need = (len + payload - 1) / payload;
      if (need > MAX_CHAIN) begin
        push_result(ST_TOO_LARGE, 0, 0, 0, 0, 1);
        return;
      end
      take_blocks(need, ok, start);
      if (!ok) begin
        push_result(ST_NO_SPACE, 0, 0, 0, 0, 1);
        return;
      end
      nxt  = start;
      left = len;
      while (nxt != 0 && left > 0 && n < MAX_CHAIN) begin
        cur = nxt;
        if (cur >= POOL_LIMIT) break;
        take          = (left > payload) ? payload : left;
        fill_mem[cur] = take;
        pos[n]        = cur;
        byt[n]        = take;
        n++;
        nxt = link_mem[cur];
        if (free_cnt > 0) free_cnt--;
        left -= take;
      end
      // A chain that runs out before the length is used up is reported as
      // a bad position, and the old chain stays where it was.
      if (left != 0 || n == 0) begin
        push_result(ST_BAD_POS, 0, 0, 0, 0, 1);
        return;
      end
      link_mem[cur] = 0;
      if (head != 0) park_chain(head);
      run = 0;
      for (int unsigned i = 0; i < n; i++) begin
        run += byt[i];
        push_result(ST_OK, start, pos[i], byt[i], run, (i + 1 == n));
      end
      return;
    end
    if (cap < payload) begin
      push_result(ST_SMALL_BUF, 0, 0, 0, 0, 1);
      return;
    end
    nxt = head;
    while (nxt != 0) begin
      if (n >= MAX_CHAIN) begin
        push_result(ST_TOO_LONG, 0, 0, 0, 0, 1);
        return;
      end
      cur = nxt;
      if (cur >= POOL_LIMIT) begin
        push_result(ST_BAD_POS, 0, 0, 0, 0, 1);
        return;
      end
      if (total + payload > cap) begin
        push_result(ST_OVERFLOW, 0, 0, 0, 0, 1);
        return;
      end
      if (link_mem[cur] != 0) b = payload;
      else b = (fill_mem[cur] > payload) ? payload : fill_mem[cur];
      total += b;
      pos[n] = cur;
      byt[n] = b;
      n++;
      nxt = link_mem[cur];
    end
    if (n == 0) begin
      push_result(ST_OK, 0, 0, 0, 0, 1);
      return;
    end
    run = 0;
    for (int unsigned i = 0; i < n; i++) begin
      run += byt[i];
      push_result(ST_OK, 0, pos[i], byt[i], run, (i + 1 == n));
    end
  endtask

  task automatic apply_config(input logic [0:0] idx, input int unsigned value);
    if (idx == CFG_PAYLOAD) begin
      if (value >= 1 && value <= PAY_MAX) payload = value;
    end else begin
      if (value >= 1 && value <= RING_MAX) begin
        flush_ring();
        ring_size = value;
      end
    end
  endtask

  task automatic check_result();
    alloc_result_t got, exp;
    got.status      = out_tuser;
    got.new_head    = out_tdata[11:0];
    got.block_pos   = out_tdata[23:12];
    got.block_bytes = out_tdata[36:24];
    got.total_bytes = out_tdata[55:37];
    got.free_blocks = out_tdata[67:56];
    got.last        = out_tlast;
    if (expected_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("unexpected result transaction: %p", got);
      return;
    end
    exp = expected_q.pop_front();
    if (got != exp) begin
      fail_count++;
      if (fail_count <= 10) $display("result mismatch: expected %p, got %p", exp, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_result();
      if (cfg_valid && cfg_ready) apply_config(cfg_index, cfg_data);
      if (in_tvalid && in_tready)
        predict_item(in_tuser, in_tdata[11:0], in_tdata[30:12], in_tdata[49:31]);
    end
  end

endmodule

@@ tb/chained_block_allocator_top_tb.sv @@
`timescale 1ns / 1ps
// Top of the allocator testbench. It makes the stimulus, drives the three
// channels and gives the verdict; all prediction and comparison live in the
// checker instantiated beside the block.
module chained_block_allocator_top_tb;
  import cba_pkg::*;

  localparam int NUM_BLOCKS  = 4096;
  localparam int MAX_CHAIN   = 64;
  localparam int RING_MAX    = 16;
  localparam int CYCLE_LIMIT = 1000000;
  // Cycles allowed after the last result for any release walk still running.
  localparam int SETTLE      = 3000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic [1:0]  in_tuser = OP_STORE;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = CFG_PAYLOAD;
  logic [12:0] cfg_data = '0;

  int fail_count;
  int pending;
  int cycle_count = 0;

  // Shared between stimulus and the ready process: no idling while quiet is
  // set, and a single long hold-off of the result channel on request.
  bit quiet = 1'b0;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  // Heads of chains that the block reported as stored, used as targets for
  // later reads, erases and re-stores.
  logic [11:0] stored_heads[$];
  int unsigned cur_payload = 64;

  always #2 clk = ~clk;

  chained_block_allocator_top #(
    .NUM_BLOCKS(NUM_BLOCKS), .MAX_CHAIN(MAX_CHAIN), .RING_MAX(RING_MAX)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  chain_alloc_checker #(
    .NUM_BLOCKS(NUM_BLOCKS), .MAX_CHAIN(MAX_CHAIN), .RING_MAX(RING_MAX)
  ) checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // The run is cut short if it ever exceeds the cycle budget.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result channel ready. The long hold-off is counted here so that the
  // sender keeps offering transactions while the block backs up.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_done  <= 1'b1;
      hold_left  <= 1500;
      out_tready <= 1'b0;
    end else if (quiet) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= 15);
    end
  end

  // Collect the head of every successful non-empty store.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready && out_tlast && out_tuser == ST_OK &&
        out_tdata[11:0] != 0) begin
      stored_heads.push_back(out_tdata[11:0]);
      if (stored_heads.size() > 32) void'(stored_heads.pop_front());
    end
  end

  // Offers one input transaction and returns once it has been accepted.
  // Valid is left high so that back-to-back transactions need no gap.
  task automatic send_item(input logic [1:0] op, input logic [11:0] head,
                           input logic [18:0] len, input logic [18:0] cap);
    while (!quiet && $urandom_range(0, 99) < 15) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'd0, cap, len, head};
    do @(posedge clk); while (!in_tready);
  endtask

  // Waits until every expected result has come back, then lets any trailing
  // chain release finish before the block is touched again.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [0:0] idx, input int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[12:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_PAYLOAD && value >= 1 && value <= PAY_MAX) cur_payload = value;
  endtask

  function automatic logic [11:0] pick_head();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60 && stored_heads.size() != 0)
      return stored_heads[$urandom_range(0, stored_heads.size() - 1)];
    if (r < 70) return 12'd0;
    if (r < 75) return ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'hFFE;
    return $urandom_range(0, 4095);
  endfunction

  // Mostly lengths that fit within a chain under the current payload size;
  // now and then the whole field at random, which mainly hits too-large.
  function automatic logic [18:0] pick_len();
    int unsigned r, top;
    r   = $urandom_range(0, 99);
    top = cur_payload * MAX_CHAIN;
    if (top > 262144) top = 262144;
    if (r < 5) return 19'd0;
    if (r < 15) return $urandom_range(0, 19'h7FFFF);
    if (r < 60) return $urandom_range(1, (top < 4 * cur_payload) ? top : 4 * cur_payload);
    return $urandom_range(1, top);
  endfunction

  function automatic logic [18:0] pick_cap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom_range(0, cur_payload);
    if (r < 30) return $urandom_range(0, 19'h7FFFF);
    return 19'h7FFFF - $urandom_range(0, 1000);
  endfunction

  task automatic random_items(input int count);
    int unsigned r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) send_item(OP_STORE, pick_head(), pick_len(), $urandom_range(0, 19'h7FFFF));
      else if (r < 75) send_item(OP_READ, pick_head(), $urandom_range(0, 19'h7FFFF), pick_cap());
      else if (r < 93) send_item(OP_ERASE, pick_head(), $urandom_range(0, 19'h7FFFF),
                                 $urandom_range(0, 19'h7FFFF));
      else send_item(OP_FLUSH, $urandom_range(0, 4095), $urandom_range(0, 19'h7FFFF),
                     $urandom_range(0, 19'h7FFFF));
    end
  endtask

  function automatic logic [11:0] last_head();
    return (stored_heads.size() != 0) ? stored_heads[$] : 12'd1;
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed transactions under the reset settings of 64 bytes per block
    // and a ring of eight.
    send_item(OP_STORE, 12'd0, 19'd0, 19'd0);            // empty chain
    send_item(OP_STORE, 12'd0, 19'd1, 19'd0);
    send_item(OP_STORE, 12'd0, 19'd4096, 19'd0);         // exactly the longest chain
    send_item(OP_STORE, 12'd0, 19'd4097, 19'd0);         // one block too many
    wait_drained();
    send_item(OP_READ, last_head(), 19'd0, 19'd63);      // buffer below one block
    send_item(OP_READ, 12'd0, 19'd0, 19'd64);            // empty chain read
    send_item(OP_READ, last_head(), 19'd0, 19'h7FFFF);
    send_item(OP_READ, last_head(), 19'd0, 19'd100);     // buffer overflows
    send_item(OP_READ, 12'hFFF, 19'd0, 19'h7FFFF);       // bad position
    send_item(OP_READ, 12'hFFE, 19'd0, 19'h7FFFF);
    send_item(OP_ERASE, 12'd0, 19'd0, 19'd0);            // parks a zero
    send_item(OP_ERASE, 12'hFFF, 19'h7FFFF, 19'h7FFFF);  // bad head is parked, frees nothing
    send_item(OP_STORE, last_head(), 19'd200, 19'd0);    // re-store parks the old chain
    send_item(OP_STORE, 12'hFFF, 19'h7FFFF, 19'h7FFFF);
    send_item(OP_FLUSH, 12'hFFF, 19'h7FFFF, 19'h7FFFF);
    send_item(OP_STORE, 12'hFFE, 19'd10, 19'd0);
    send_item(OP_FLUSH, 12'd0, 19'd0, 19'd0);
    wait_drained();

    // Random phases, each under a different setting, including ignored
    // out-of-range writes and both extremes of each register.
    write_cfg(CFG_PAYLOAD, 1);
    write_cfg(CFG_RING, 1);
    random_items(60);
    wait_drained();

    write_cfg(CFG_PAYLOAD, 0);                           // ignored
    write_cfg(CFG_RING, 17);                             // ignored, ring kept
    write_cfg(CFG_PAYLOAD, 4096);
    write_cfg(CFG_RING, 16);
    random_items(40);
    // Stores that never park their old chain drain the pool until the
    // allocator runs out of space.
    for (int i = 0; i < 70; i++) send_item(OP_STORE, 12'd0, 19'd262144, 19'd0);
    random_items(30);
    wait_drained();

    write_cfg(CFG_PAYLOAD, 8191);                        // ignored
    write_cfg(CFG_PAYLOAD, 64);
    write_cfg(CFG_RING, 8);
    // A stretch with no idling on either side, then a long hold-off of the
    // result channel while transactions keep being offered.
    quiet = 1'b1;
    random_items(50);
    quiet = 1'b0;
    hold_request = 1'b1;
    random_items(40);
    wait_drained();

    write_cfg(CFG_PAYLOAD, $urandom_range(2, 300));
    write_cfg(CFG_RING, $urandom_range(2, 15));
    random_items(60);
    send_item(OP_FLUSH, 12'd0, 19'd0, 19'd0);
    wait_drained();

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
